[design/irdma_pkg.sv]
// Package for the IR distance moving average block.
// Shared types and fixed conversion constants; no dependencies.
`default_nettype none

package irdma_pkg;

  typedef logic [9:0] sample_t;
  typedef logic [8:0] refcv_t;
  typedef logic [9:0] dist_t;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // centivolt conversion: divide by 1023 via reciprocal 2^20/1023
  localparam logic [9:0]  ADC_FULL   = 10'd1023;
  // piecewise map
  localparam logic [9:0]  V_LOW      = 10'd50;
  localparam logic [9:0]  V_HIGH     = 10'd220;
  localparam logic [9:0]  V_KNEE     = 10'd55;
  localparam logic [9:0]  DIST_FAR   = 10'd500;
  localparam logic [16:0] DIST_SPAN  = 17'd460;
  localparam logic [16:0] V_SPAN     = 17'd165;
  localparam logic [26:0] V_SPAN_RCP = 27'd794;  // floor(2^17 / 165)

endpackage

`default_nettype wire

[design/irdma_front.sv]
// Front end: accepts samples and converts each to a distance in a stall-able pipeline.
// Depends on irdma_pkg.
`default_nettype none

module irdma_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push,
  output logic                full,
  input  wire irdma_pkg::sample_t adc_sample_i,
  input  wire irdma_pkg::refcv_t  ref_i,
  output logic                q_push_o,
  output irdma_pkg::dist_t    q_data_o,
  input  wire                 q_full_i
);

  logic        adv;
  logic [4:0]  vld_q, vld_d;

  logic [18:0] x1_q;
  logic [18:0] x2_q;
  logic [9:0]  q2_q;
  logic [7:0]  d3_q;
  logic        far3_q, blw3_q;
  logic [16:0] p4_q;
  logic        far4_q, blw4_q;
  logic [16:0] p5_q;
  logic [9:0]  q5_q;
  logic        far5_q, blw5_q;

  logic [29:0] prod2;
  logic [19:0] q0m3, rem3;
  logic [9:0]  v3;
  logic [26:0] prod5;
  logic [16:0] qm6, rem6;
  logic [9:0]  step6;

  assign adv  = !(vld_q[4] && q_full_i);
  assign full = !adv;

  assign vld_d = {vld_q[3:0], push};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  assign prod2 = {1'b0, x1_q, 10'd0} + {11'd0, x1_q};

  assign q0m3 = {q2_q, 10'd0} - {10'd0, q2_q};
  assign rem3 = {1'b0, x2_q} - q0m3;
  assign v3   = q2_q + {9'd0, (rem3 >= {10'd0, irdma_pkg::ADC_FULL})};

  assign prod5 = {10'd0, p4_q} * irdma_pkg::V_SPAN_RCP;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x1_q   <= {9'd0, adc_sample_i} * {10'd0, ref_i};
      x2_q   <= x1_q;
      q2_q   <= prod2[29:20];
      far3_q <= (v3 < irdma_pkg::V_LOW) || (v3 > irdma_pkg::V_HIGH);
      blw3_q <= v3 < irdma_pkg::V_KNEE;
      d3_q   <= (v3 < irdma_pkg::V_KNEE) ? 8'(irdma_pkg::V_KNEE - v3)
                                         : 8'(v3 - irdma_pkg::V_KNEE);
      p4_q   <= {9'd0, d3_q} * irdma_pkg::DIST_SPAN;
      far4_q <= far3_q;
      blw4_q <= blw3_q;
      p5_q   <= p4_q;
      q5_q   <= prod5[26:17];
      far5_q <= far4_q;
      blw5_q <= blw4_q;
    end
  end

  assign qm6   = {7'd0, q5_q} * irdma_pkg::V_SPAN;
  assign rem6  = p5_q - qm6;
  assign step6 = q5_q + {9'd0, (rem6 >= irdma_pkg::V_SPAN)};

  assign q_push_o = vld_q[4];
  assign q_data_o = far5_q ? irdma_pkg::DIST_FAR
                  : blw5_q ? irdma_pkg::DIST_FAR + step6
                           : irdma_pkg::DIST_FAR - step6;

endmodule

`default_nettype wire

[design/irdma_fifo.sv]
// Short word queue between the front end and the averaging back end.
// Depends on irdma_pkg.
`default_nettype none

module irdma_fifo (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  wire irdma_pkg::dist_t data_i,
  output logic                full_o,
  input  wire                 pop_i,
  output irdma_pkg::dist_t    data_o,
  output logic                empty_o
);

  localparam int unsigned PW = irdma_pkg::QPTR_W;

  irdma_pkg::dist_t mem_q [irdma_pkg::QUEUE_DEPTH];
  logic [PW-1:0]    wp_q, rp_q;
  logic [PW:0]      cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == (PW+1)'(irdma_pkg::QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= wp_q + 1'b1;
      if (do_pop)  rp_q <= rp_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= data_i;
  end

endmodule

`default_nettype wire

[design/irdma_back.sv]
// Back end: window ring, running sum, priming and mean by reciprocal multiply.
// Depends on irdma_pkg.
`default_nettype none

module irdma_back #(
  parameter int unsigned WINDOW_DEPTH = 10
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 q_empty_i,
  input  wire irdma_pkg::dist_t q_data_i,
  output logic                q_pop_o,
  input  wire                 pop,
  output logic                empty,
  output irdma_pkg::dist_t    average_distance_o,
  output irdma_pkg::dist_t    sample_distance_o
);

  localparam int unsigned SLOT_W = $clog2(WINDOW_DEPTH);
  localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SUM_W  = 10 + $clog2(WINDOW_DEPTH);
  localparam int unsigned RECIP  = (1 << SUM_W) / WINDOW_DEPTH;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIX  = 2'd2;

  logic [1:0]        state_q, state_d;
  irdma_pkg::dist_t  win_q [WINDOW_DEPTH];
  logic [SUM_W-1:0]  sum_q;
  logic [SLOT_W-1:0] slot_q;
  logic [CNT_W-1:0]  cnt_q;
  irdma_pkg::dist_t  dist_q;
  logic [9:0]        q0_q;
  logic              ovld_q;
  irdma_pkg::dist_t  avg_q, sdist_q;

  logic              primed, take, wr_out;
  logic [SUM_W-1:0]  old_d, sum_d;
  logic [2*SUM_W-1:0] prod;
  logic [SUM_W-1:0]  qm, rem;

  assign primed = cnt_q == CNT_W'(WINDOW_DEPTH);
  assign take   = (state_q == ST_IDLE) && !q_empty_i;
  assign wr_out = (state_q == ST_FIX) && (!ovld_q || pop);
  assign q_pop_o = take;

  assign old_d = primed ? SUM_W'(win_q[slot_q]) : '0;
  assign sum_d = sum_q - old_d + SUM_W'(q_data_i);

  assign prod = (2*SUM_W)'(sum_q) * (2*SUM_W)'(RECIP);
  assign qm   = SUM_W'(q0_q) * SUM_W'(WINDOW_DEPTH);
  assign rem  = sum_q - qm;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (take && primed) state_d = ST_DIV;
      ST_DIV:  state_d = ST_FIX;
      ST_FIX:  if (wr_out) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sum_q   <= '0;
      slot_q  <= '0;
      cnt_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (take) begin
        sum_q  <= sum_d;
        slot_q <= (slot_q == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_q + 1'b1;
        if (!primed) cnt_q <= cnt_q + 1'b1;
      end
      if (wr_out) ovld_q <= 1'b1;
      else if (pop) ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      win_q[slot_q] <= q_data_i;
      dist_q        <= q_data_i;
    end
    if (state_q == ST_DIV) q0_q <= prod[SUM_W +: 10];
    if (wr_out) begin
      avg_q   <= q0_q + {9'd0, (rem >= SUM_W'(WINDOW_DEPTH))};
      sdist_q <= dist_q;
    end
  end

  assign empty              = !ovld_q;
  assign average_distance_o = avg_q;
  assign sample_distance_o  = sdist_q;

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SLOT_W'(WINDOW_DEPTH - 1))
    else $error("ring slot out of range");

  a_div_primed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> primed)
    else $error("mean computed before window primed");

  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q <= SUM_W'(513 * WINDOW_DEPTH))
    else $error("window sum exceeds bound");

  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV || state_q == ST_FIX) |-> !q_pop_o)
    else $error("queue popped while back end busy");

endmodule

`default_nettype wire

[design/ir_distance_moving_average_core.sv]
// Top level of the IR distance moving average block.
// Depends on irdma_pkg, irdma_front, irdma_fifo, irdma_back.
//
// Usage:
//   Input: drive adc_sample_i and raise push; the word is taken at a clock
//   edge with push high and full low. Results: while empty is low,
//   average_distance_o and sample_distance_o hold the oldest result; pop
//   with empty low takes it.
//   Config: reference_centivolts_i is written when cfg_valid_i is high
//   (cfg_ready_o is always high); reset value 330. Write only when idle.
//   Path: from accepted sample to result, 4 convert stages after the input
//   register, queue write, 3 back-end steps. The front pipeline takes one
//   word per cycle while full is low; the back end takes a new word only
//   when idle, after its window update / reciprocal multiply / correction
//   sequence for the last word is done.
//   The first WINDOW_DEPTH samples after reset only fill the window.
//   Reset clears the sum, ring pointer, priming count and all queues.
//   If pop stays low, the result register holds, the back end stops, the
//   4-word queue fills and then full rises.
`default_nettype none

module ir_distance_moving_average_core #(
  parameter int unsigned WINDOW_DEPTH = 10
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push,
  output logic                  full,
  input  wire irdma_pkg::sample_t adc_sample_i,
  input  wire                   cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire irdma_pkg::refcv_t  reference_centivolts_i,
  output logic                  empty,
  input  wire                   pop,
  output irdma_pkg::dist_t      average_distance_o,
  output irdma_pkg::dist_t      sample_distance_o
);

  irdma_pkg::refcv_t ref_q;
  logic              q_push, q_full, q_pop, q_empty;
  irdma_pkg::dist_t  q_wdata, q_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= 9'd330;
    end else if (cfg_valid_i) begin
      ref_q <= reference_centivolts_i;
    end
  end

  irdma_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .adc_sample_i(adc_sample_i),
    .ref_i       (ref_q),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata),
    .q_full_i    (q_full)
  );

  irdma_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .empty_o(q_empty)
  );

  irdma_back #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_empty_i         (q_empty),
    .q_data_i          (q_rdata),
    .q_pop_o           (q_pop),
    .pop               (pop),
    .empty             (empty),
    .average_distance_o(average_distance_o),
    .sample_distance_o (sample_distance_o)
  );

endmodule

`default_nettype wire
